// ----- src/ftss_pkg.sv -----
// shared types and constants for the fixed-timestep step scheduler
// used by ftss_divider and fixed_timestep_step_scheduler; no dependencies
package ftss_pkg;

  // field widths
  localparam int unsigned TickW  = 32;
  localparam int unsigned AlphaW = 16;
  localparam int unsigned TotalW = 64;
  localparam int unsigned SumW   = TickW + 1;

  // divider: dividend shift register and iteration counter
  localparam int unsigned DivW   = SumW;
  localparam int unsigned IterW  = 6;

  // iteration counts for the two divisions
  localparam logic [IterW-1:0] QuotIters = IterW'(SumW);
  localparam logic [IterW-1:0] FracIters = IterW'(AlphaW);

  // stream widths, whole bytes
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutFldW  = TickW + AlphaW + 2 + TotalW + TickW;
  localparam int unsigned OutDataW = ((OutFldW + 7) / 8) * 8;

  // configuration register indexes
  localparam logic CfgStepTicks    = 1'b0;
  localparam logic CfgMaxFrameTicks = 1'b1;

  // register defaults, also used when a register holds zero
  localparam logic [TickW-1:0] DefaultStepTicks     = TickW'(16667);
  localparam logic [TickW-1:0] DefaultMaxFrameTicks = TickW'(250000);

  localparam logic [TickW-1:0]  TickMax  = '1;
  localparam logic [AlphaW-1:0] AlphaMax = '1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_QUOT,
    S_FRAC_GO,
    S_FRAC,
    S_OUT
  } state_e;

  // start request to the serial divider
  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [TickW-1:0] rem_init;
    logic [TickW-1:0] divisor;
    logic [IterW-1:0] iters;
  } div_req_t;

  // divider result
  typedef struct packed {
    logic             done;
    logic [DivW-1:0]  quo;
    logic [TickW-1:0] rem;
  } div_rsp_t;

endpackage

// ----- src/ftss_divider.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// depends on ftss_pkg for widths and the request/response structs
module ftss_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ftss_pkg::div_req_t req_i,
  output ftss_pkg::div_rsp_t rsp_o
);
  import ftss_pkg::*;

  logic [TickW-1:0] r_q, r_d;
  logic [DivW-1:0]  d_q;
  logic [TickW-1:0] div_q;
  logic [IterW-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [SumW-1:0] trial;
  logic [SumW-1:0] diff;
  logic            ge;

  // one shift-subtract step
  always_comb begin
    trial = {r_q, d_q[DivW-1]};
    diff  = trial - {1'b0, div_q};
    ge    = trial >= {1'b0, div_q};
    r_d   = ge ? diff[TickW-1:0] : trial[TickW-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.iters;
    end else if (busy_q) begin
      cnt_q <= cnt_q - IterW'(1);
      if (cnt_q == IterW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath: partial remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q   <= req_i.rem_init;
      d_q   <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      r_q <= r_d;
      d_q <= {d_q[DivW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = d_q;
  assign rsp_o.rem  = r_q;

  // checks
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !$past(req_i.start) |-> r_q < div_q)
    else $error("partial remainder not below divisor");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held for more than one cycle");

endmodule

// ----- src/fixed_timestep_step_scheduler.sv -----
// top level of the fixed-timestep step scheduler: sequencer, state and beat registers
// depends on ftss_pkg and ftss_divider
//
// Each input beat carries one frame delta in ticks; the block returns one result beat
// with the steps due, the Q0.16 leftover fraction and the running totals. The result
// beat is computed by the single shared one-bit-per-cycle divider: first the step
// quotient (skipped for a zero delta), then the fraction. While the remainder is not
// below the step the fraction division is skipped. The next frame can be taken in the
// cycle after the result is loaded. A new frame is taken whenever the sequencer is
// idle, even while the previous result still waits in the output register.
// Configuration writes take effect at once and must only happen while no frame is in
// flight.
module fixed_timestep_step_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ftss_pkg::TickW-1:0]    cfg_wdata_i,
  // frame input: [31:0] frame_delta_ticks
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ftss_pkg::InDataW-1:0]  s_axis_tdata,
  // result: [31:0] steps_due, [47:32] alpha_q16, [48] was_clamped,
  // [49] was_rejected, [113:50] total_steps_issued, [145:114] clamped_frame_total
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ftss_pkg::OutDataW-1:0] m_axis_tdata
);
  import ftss_pkg::*;

  state_e state_q, state_d;

  logic [TickW-1:0]  step_q, max_frame_q;
  logic [TickW-1:0]  rem_q;
  logic [TotalW-1:0] issued_q;
  logic [TickW-1:0]  clamp_cnt_q;
  logic [TickW-1:0]  due_q;
  logic [AlphaW-1:0] alpha_q;
  logic              clamped_q, rejected_q;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [TickW-1:0] eff_step, eff_max, delta_in, delta_clamp, due_sat;
  logic             in_acc, in_rej, in_clamp, rem_ge, out_free;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // effective registers and input decode
  always_comb begin
    eff_step    = (step_q != '0) ? step_q : DefaultStepTicks;
    eff_max     = (max_frame_q != '0) ? max_frame_q : DefaultMaxFrameTicks;
    delta_in    = s_axis_tdata[TickW-1:0];
    in_rej      = (delta_in == '0);
    in_clamp    = !in_rej && (delta_in > eff_max);
    delta_clamp = in_clamp ? eff_max : delta_in;
    in_acc      = s_axis_tvalid && s_axis_tready;
    rem_ge      = rem_q >= eff_step;
    out_free    = !out_valid_q || m_axis_tready;
    due_sat     = div_rsp.quo[DivW-1] ? TickMax : div_rsp.quo[TickW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_acc) state_d = in_rej ? S_FRAC_GO : S_QUOT;
      S_QUOT:    if (div_rsp.done) state_d = S_FRAC_GO;
      S_FRAC_GO: state_d = rem_ge ? S_OUT : S_FRAC;
      S_FRAC:    if (div_rsp.done) state_d = S_OUT;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, rem_q} + {1'b0, delta_clamp};
    div_req.rem_init = '0;
    div_req.divisor  = eff_step;
    div_req.iters    = QuotIters;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        div_req.start = s_axis_tvalid && !in_rej;
      end
      S_FRAC_GO: begin
        div_req.start    = !rem_ge;
        div_req.dividend = '0;
        div_req.rem_init = rem_q;
        div_req.iters    = FracIters;
      end
      default: ;
    endcase
  end

  ftss_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // state, configuration and running totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= DefaultStepTicks;
      max_frame_q <= DefaultMaxFrameTicks;
      rem_q       <= '0;
      issued_q    <= '0;
      clamp_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStepTicks:     step_q      <= cfg_wdata_i;
          CfgMaxFrameTicks: max_frame_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_acc && in_clamp && clamp_cnt_q != TickMax) begin
        clamp_cnt_q <= clamp_cnt_q + TickW'(1);
      end
      if (state_q == S_QUOT && div_rsp.done) begin
        rem_q    <= div_rsp.rem;
        issued_q <= issued_q + {{(TotalW-TickW){1'b0}}, due_sat};
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-frame result fields and the output beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      clamped_q  <= in_clamp;
      rejected_q <= in_rej;
      due_q      <= '0;
    end
    if (state_q == S_QUOT && div_rsp.done) begin
      due_q <= due_sat;
    end
    if (state_q == S_FRAC_GO && rem_ge) begin
      alpha_q <= AlphaMax;
    end
    if (state_q == S_FRAC && div_rsp.done) begin
      alpha_q <= div_rsp.quo[AlphaW-1:0];
    end
    if (state_q == S_OUT && out_free) begin
      out_data_q <= OutDataW'({clamp_cnt_q, issued_q, rejected_q, clamped_q, alpha_q, due_q});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- verif/step_sched_checker.sv -----
`timescale 1ns / 100ps
// result checker for the fixed-timestep step scheduler: shadows the registers, predicts
// each result beat from the accepted frame beats and compares it field by field
// depends on ftss_pkg
module step_sched_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ftss_pkg::TickW-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // [31:0] frame_delta_ticks
  input  logic [ftss_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] steps_due, [47:32] alpha_q16, [48] was_clamped, [49] was_rejected,
  // [113:50] total_steps_issued, [145:114] clamped_frame_total
  input  logic [ftss_pkg::OutDataW-1:0] m_axis_tdata,
  output int unsigned                   pending_o,
  output int unsigned                   errors_o
);
  import ftss_pkg::*;

  // one result beat, steps_due (the last member) at the bottom so that it lines up with tdata
  typedef struct packed {
    logic [TickW-1:0]  clamp_total;
    logic [TotalW-1:0] steps_total;
    logic              rejected;
    logic              clamped;
    logic [AlphaW-1:0] alpha;
    logic [TickW-1:0]  steps_due;
  } frame_result_t;

  // shadow registers and scheduler state
  logic [TickW-1:0]  step_reg;
  logic [TickW-1:0]  max_frame_reg;
  logic [TickW-1:0]  remainder;
  logic [TotalW-1:0] steps_issued;
  logic [TickW-1:0]  clamp_count;

  frame_result_t     expected_q[$];
  int unsigned       mismatch_count = 0;
  int unsigned       result_idx = 0;

  assign errors_o = mismatch_count;

  // advance the scheduler by one frame and return the result beat it gives
  function automatic frame_result_t predict_frame(input logic [TickW-1:0] delta_in);
    logic [TickW-1:0]        step_eff;
    logic [TickW-1:0]        max_eff;
    logic [TickW-1:0]        delta;
    logic [SumW-1:0]         sum;
    logic [SumW-1:0]         quot;
    logic [TickW+AlphaW-1:0] frac;
    frame_result_t           r;
    step_eff = (step_reg != '0) ? step_reg : DefaultStepTicks;
    max_eff  = (max_frame_reg != '0) ? max_frame_reg : DefaultMaxFrameTicks;
    r        = '0;
    delta    = delta_in;
    if (delta == '0) begin
      r.rejected = 1'b1;
    end else begin
      // clamp long frames, counter sticks at full scale
      if (delta > max_eff) begin
        delta     = max_eff;
        r.clamped = 1'b1;
        if (clamp_count != TickMax) clamp_count = clamp_count + TickW'(1);
      end
      sum          = {1'b0, remainder} + {1'b0, delta};
      quot         = sum / {1'b0, step_eff};
      remainder    = TickW'(sum % {1'b0, step_eff});
      r.steps_due  = quot[SumW-1] ? TickMax : quot[TickW-1:0];
      steps_issued = steps_issued + TotalW'(r.steps_due);
    end
    // leftover fraction, pinned at full scale while an old remainder is not below the step
    if (remainder >= step_eff) begin
      r.alpha = AlphaMax;
    end else begin
      frac    = {remainder, AlphaW'(0)} / {AlphaW'(0), step_eff};
      r.alpha = frac[AlphaW-1:0];
    end
    r.steps_total = steps_issued;
    r.clamp_total = clamp_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [TotalW-1:0] got,
                                 input logic [TotalW-1:0] want);
    $display("%0t: result %0d: %s is 0x%0h, expected 0x%0h",
             $time, result_idx, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [TotalW-1:0] got,
                             input logic [TotalW-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_ni) begin
      step_reg      = DefaultStepTicks;
      max_frame_reg = DefaultMaxFrameTicks;
      remainder     = '0;
      steps_issued  = '0;
      clamp_count   = '0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      // result beat against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = frame_result_t'(m_axis_tdata[OutFldW-1:0]);
        if (expected_q.size() == 0) begin
          report_mismatch("beat with no frame outstanding, steps_due",
                          TotalW'(got.steps_due), '0);
        end else begin
          want = expected_q.pop_front();
          check_field("steps_due", TotalW'(got.steps_due), TotalW'(want.steps_due));
          check_field("alpha_q16", TotalW'(got.alpha), TotalW'(want.alpha));
          check_field("was_clamped", TotalW'(got.clamped), TotalW'(want.clamped));
          check_field("was_rejected", TotalW'(got.rejected), TotalW'(want.rejected));
          check_field("total_steps_issued", got.steps_total, want.steps_total);
          check_field("clamped_frame_total", TotalW'(got.clamp_total),
                      TotalW'(want.clamp_total));
        end
        result_idx++;
      end
      // frame beat
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_frame(s_axis_tdata[TickW-1:0]));
      end
      // register writes, only ever made while no frame is in flight
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgStepTicks) step_reg = cfg_wdata_i;
        else max_frame_reg = cfg_wdata_i;
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// top of the step scheduler testbench: clock, reset, frame and register stimulus, verdict
// depends on ftss_pkg, fixed_timestep_step_scheduler and step_sched_checker
module testbench;
  import ftss_pkg::*;

  localparam int unsigned HoldCycles     = 600;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned RandomPhases   = 6;
  localparam int unsigned FramesPerPhase = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [TickW-1:0]    cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [31:0] frame_delta_ticks
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [31:0] steps_due, [47:32] alpha_q16, [48] was_clamped, [49] was_rejected,
  // [113:50] total_steps_issued, [145:114] clamped_frame_total
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned         pending_frames;
  int unsigned         mismatches;
  int unsigned         frames_sent   = 0;
  int unsigned         settings_used = 0;
  int unsigned         stall_cycles  = 0;
  bit                  quiet     = 1'b0;
  bit                  hold_req  = 1'b0;
  bit                  hold_done = 1'b0;

  // register values as the block will use them, for shaping the deltas
  logic [TickW-1:0]    step_eff = DefaultStepTicks;
  logic [TickW-1:0]    max_eff  = DefaultMaxFrameTicks;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  fixed_timestep_step_scheduler dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  step_sched_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .pending_o    (pending_frames),
    .errors_o     (mismatches)
  );

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("timeout after %0d cycles without a beat", stall_cycles);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 27);
      end
    end
  end

  // offer one frame beat, with random gaps ahead of it, and wait for it to be taken
  task automatic send_frame(input logic [TickW-1:0] delta);
    while (!quiet && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= delta;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    frames_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [TickW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_frames != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [TickW-1:0] new_step, input logic [TickW-1:0] new_max);
    write_reg(CfgStepTicks, new_step);
    write_reg(CfgMaxFrameTicks, new_max);
    step_eff = (new_step != '0) ? new_step : DefaultStepTicks;
    max_eff  = (new_max != '0) ? new_max : DefaultMaxFrameTicks;
    settings_used++;
  endtask

  // delta mix: rejects, clamps around the limit, up to four steps' worth, tiny deltas, full range
  function automatic logic [TickW-1:0] random_delta();
    logic [TotalW-1:0] span;
    span = TotalW'(step_eff) * 4;
    case ($urandom_range(9))
      0:       return '0;
      1:       return TickMax;
      2:       return max_eff;
      3:       return max_eff + TickW'($urandom_range(1, 8));
      4, 5:    return (span > TotalW'(TickMax)) ? $urandom
                                                : $urandom_range(1, span[TickW-1:0]);
      6:       return TickW'($urandom_range(1, 16));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [TickW-1:0] new_step;
    logic [TickW-1:0] new_max;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgStepTicks;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: smallest delta, whole steps, reject, limit and clamps
    send_frame(32'd1);
    send_frame(32'd16666);
    send_frame(32'd16667);
    send_frame('0);
    send_frame(32'd250000);
    send_frame(32'd250001);
    send_frame(TickMax);
    send_frame('0);

    // zero in both registers falls back to the defaults
    drain();
    set_config('0, '0);
    send_frame(32'd33333);
    send_frame(32'd300000);
    send_frame('0);

    // largest step, with a frame just short of it on top of the carried remainder
    drain();
    set_config(TickMax, TickMax);
    send_frame(TickMax - 1);
    send_frame('0);

    // step shrinks under that remainder: fraction pinned, then quotient saturates
    drain();
    set_config(32'd1, TickMax);
    send_frame('0);
    send_frame(TickMax);
    send_frame(32'd1);

    // one-tick frame limit
    drain();
    set_config(32'd7, 32'd1);
    send_frame(32'd5);
    send_frame(32'd1);
    send_frame(32'h8000_0000);
    send_frame('0);

    // random register settings, each with a burst of random frames
    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      case ($urandom_range(4))
        0:       new_step = '0;
        1:       new_step = TickW'($urandom_range(1, 64));
        2:       new_step = TickW'($urandom_range(1000, 100000));
        3:       new_step = $urandom;
        default: new_step = TickMax;
      endcase
      case ($urandom_range(4))
        0:       new_max = '0;
        1:       new_max = TickW'($urandom_range(1, 1000));
        2:       new_max = TickW'($urandom_range(10000, 1000000));
        3:       new_max = $urandom;
        default: new_max = TickMax;
      endcase
      set_config(new_step, new_max);
      // first burst runs without gaps on either side
      quiet = (p == 0);
      for (int i = 0; i < FramesPerPhase; i++) begin
        // long result stall while frames keep coming
        if (p == 2 && i == 10) hold_req = 1'b1;
        send_frame(random_delta());
      end
    end
    quiet = 1'b0;

    drain();
    // room for a stray result beat to show up
    repeat (64) @(posedge clk_i);
    $display("ran %0d frames under %0d register settings incl. zero, one and all-ones",
             frames_sent, settings_used);
    $display("rejects, clamps, quotient saturation, step cut under a remainder, %0d-cycle stall",
             HoldCycles);
    if (mismatches == 0 && pending_frames == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ftss_pkg.sv
src/ftss_divider.sv
src/fixed_timestep_step_scheduler.sv
verif/step_sched_checker.sv
verif/testbench.sv
